// ===== rtl/htm_pkg.sv =====
// Shared types, constants and tables for the helix-to-momentum block.
`timescale 1ns / 1ps
package htm_pkg;

    // Field widths
    localparam int CURV_W  = 24;
    localparam int AZ_W    = 16;
    localparam int SLOPE_W = 20;
    localparam int FIELD_W = 20;
    localparam int MOM_W   = 26;

    // Stream bus widths (fields packed from bit 0, padded to whole bytes)
    localparam int IN_BITS  = CURV_W + AZ_W + SLOPE_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = 3 * MOM_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // eB constant: round(2^40 * 2.99792458e-4)
    localparam int EB_W = 29;
    localparam logic [EB_W-1:0] EB_SCALE = 29'd329625293;
    localparam int PROD_W = FIELD_W + EB_W;

    // Divider: dividend is (B * C) >> 10, divisor is |curvature|
    localparam int NUM_W = PROD_W - 10;
    localparam int DIV_W = CURV_W;
    localparam int REM_W = CURV_W;
    localparam int DIV_STEPS = NUM_W;
    localparam int PT_W = NUM_W + 1;

    // Rotation unit
    localparam int CORDIC_ITERATIONS = 18;
    localparam int ATAN_LEN = 24;
    localparam int CORDIC_STEPS =
        (CORDIC_ITERATIONS > ATAN_LEN) ? ATAN_LEN : CORDIC_ITERATIONS;
    localparam int STAGE_W = $clog2(ATAN_LEN);
    localparam int XY_W = 26;
    localparam int ANG_W = 32;
    localparam logic signed [XY_W-1:0] CORDIC_START = 26'sd5094007;
    localparam int CS_SHIFT = 23;
    localparam int TAN_SHIFT = 16;

    // Output limits
    localparam logic signed [MOM_W-1:0] MOM_MAX = {1'b0, {(MOM_W-1){1'b1}}};
    localparam logic signed [MOM_W-1:0] MOM_MIN = {1'b1, {(MOM_W-1){1'b0}}};

    // Quadrant codes from the top azimuth bits
    typedef enum logic [1:0] {
        Q_FIRST  = 2'd0,
        Q_SECOND = 2'd1,
        Q_THIRD  = 2'd2,
        Q_FOURTH = 2'd3
    } t_quad;

    // Payload handed from cell to cell
    typedef struct packed {
        logic [REM_W-1:0]         rem;
        logic [NUM_W-1:0]         num;
        logic [NUM_W-1:0]         quo;
        logic [DIV_W-1:0]         div;
        logic signed [XY_W-1:0]   x;
        logic signed [XY_W-1:0]   y;
        logic signed [ANG_W-1:0]  z;
        t_quad                    quad;
        logic signed [SLOPE_W-1:0] slope;
        logic                     zero;
    } t_cell;

    // Arctangent of 2^-i in 32-bit binary angle units
    function automatic logic signed [ANG_W-1:0] atan_at(input logic [STAGE_W-1:0] idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            5'd0:  v = 32'sd536870912;
            5'd1:  v = 32'sd316933406;
            5'd2:  v = 32'sd167458907;
            5'd3:  v = 32'sd85004756;
            5'd4:  v = 32'sd42667331;
            5'd5:  v = 32'sd21354465;
            5'd6:  v = 32'sd10679838;
            5'd7:  v = 32'sd5340245;
            5'd8:  v = 32'sd2670163;
            5'd9:  v = 32'sd1335087;
            5'd10: v = 32'sd667544;
            5'd11: v = 32'sd333772;
            5'd12: v = 32'sd166886;
            5'd13: v = 32'sd83443;
            5'd14: v = 32'sd41722;
            5'd15: v = 32'sd20861;
            5'd16: v = 32'sd10430;
            5'd17: v = 32'sd5215;
            5'd18: v = 32'sd2608;
            5'd19: v = 32'sd1304;
            5'd20: v = 32'sd652;
            5'd21: v = 32'sd326;
            5'd22: v = 32'sd163;
            5'd23: v = 32'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/htm_cell.sv =====
// One cell of the chain: one restoring-divide step and, when i_rot is set, one rotation step.
`timescale 1ns / 1ps
module htm_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_vld,
    input  logic [htm_pkg::STAGE_W-1:0]  i_stage,
    input  logic                         i_rot,
    input  htm_pkg::t_cell               i_cell,
    output logic                         o_vld,
    output htm_pkg::t_cell               o_cell
);

    logic                              r_vld;
    htm_pkg::t_cell                    r_cell;
    htm_pkg::t_cell                    n_cell;
    logic [htm_pkg::REM_W:0]           w_trial;
    logic                              w_ge;
    logic signed [htm_pkg::XY_W-1:0]   w_dx;
    logic signed [htm_pkg::XY_W-1:0]   w_dy;
    logic signed [htm_pkg::ANG_W-1:0]  w_atan;

    // Divide step: bring down one dividend bit, subtract if it fits
    // Rotation step (only when i_rot is set): turn toward zero residual angle
    always_comb begin
        n_cell  = i_cell;
        w_trial = {i_cell.rem, i_cell.num[htm_pkg::NUM_W-1]};
        w_ge    = (w_trial >= {1'b0, i_cell.div});
        if (w_ge) begin
            n_cell.rem = htm_pkg::REM_W'(w_trial - {1'b0, i_cell.div});
        end else begin
            n_cell.rem = w_trial[htm_pkg::REM_W-1:0];
        end
        n_cell.num = {i_cell.num[htm_pkg::NUM_W-2:0], 1'b0};
        n_cell.quo = {i_cell.quo[htm_pkg::NUM_W-2:0], w_ge};

        w_dx   = i_cell.y >>> i_stage;
        w_dy   = i_cell.x >>> i_stage;
        w_atan = htm_pkg::atan_at(i_stage);
        if (i_rot) begin
            if (i_cell.z >= 0) begin
                n_cell.x = i_cell.x - w_dx;
                n_cell.y = i_cell.y + w_dy;
                n_cell.z = i_cell.z - w_atan;
            end else begin
                n_cell.x = i_cell.x + w_dx;
                n_cell.y = i_cell.y - w_dy;
                n_cell.z = i_cell.z + w_atan;
            end
        end
    end

    // Advance valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_vld  = r_vld;
    assign o_cell = r_cell;

endmodule

// ===== rtl/htm_mul.sv =====
// Scales sine, cosine and slope by pT in split products, then saturates.
`timescale 1ns / 1ps
module htm_mul (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_vld,
    input  logic [htm_pkg::PT_W-1:0]            i_pt,
    input  logic signed [htm_pkg::XY_W-1:0]     i_cos,
    input  logic signed [htm_pkg::XY_W-1:0]     i_sin,
    input  logic signed [htm_pkg::SLOPE_W-1:0]  i_slope,
    input  logic                                i_zero,
    output logic                                o_vld,
    output logic signed [htm_pkg::MOM_W-1:0]    o_mom_x,
    output logic signed [htm_pkg::MOM_W-1:0]    o_mom_y,
    output logic signed [htm_pkg::MOM_W-1:0]    o_mom_z,
    output logic                                o_flag
);

    localparam int HALF_W = htm_pkg::PT_W / 2;
    localparam int HI_W   = htm_pkg::PT_W - HALF_W;
    localparam int PP_W   = HI_W + 1 + htm_pkg::XY_W;
    localparam int FULL_W = htm_pkg::PT_W + 1 + htm_pkg::XY_W;

    logic [2:0]                           r_vld;
    logic [1:0]                           r_zero;
    logic signed [htm_pkg::XY_W-1:0]      w_fac [3];
    logic signed [PP_W-1:0]               r_plo [3];
    logic signed [PP_W-1:0]               r_phi [3];
    logic signed [FULL_W-1:0]             r_prod [3];
    logic signed [FULL_W-1:0]             w_shift [3];
    logic signed [htm_pkg::MOM_W-1:0]     n_mom [3];
    logic [2:0]                           w_sat;
    logic signed [htm_pkg::MOM_W-1:0]     r_mom [3];
    logic                                 r_flag;

    // Select factors per lane
    always_comb begin
        w_fac[0] = i_cos;
        w_fac[1] = i_sin;
        w_fac[2] = htm_pkg::XY_W'(i_slope);
    end

    // Shift down and saturate each lane
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (k == 2) begin
                w_shift[k] = r_prod[k] >>> htm_pkg::TAN_SHIFT;
            end else begin
                w_shift[k] = r_prod[k] >>> htm_pkg::CS_SHIFT;
            end
            if (w_shift[k] > FULL_W'(htm_pkg::MOM_MAX)) begin
                n_mom[k] = htm_pkg::MOM_MAX;
                w_sat[k] = 1'b1;
            end else if (w_shift[k] < FULL_W'(htm_pkg::MOM_MIN)) begin
                n_mom[k] = htm_pkg::MOM_MIN;
                w_sat[k] = 1'b1;
            end else begin
                n_mom[k] = w_shift[k][htm_pkg::MOM_W-1:0];
                w_sat[k] = 1'b0;
            end
        end
    end

    // Advance valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    // Partial products, sum, then saturate
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_plo[k]  <= PP_W'($signed({1'b0, i_pt[HALF_W-1:0]}) * w_fac[k]);
                r_phi[k]  <= PP_W'($signed({1'b0, i_pt[htm_pkg::PT_W-1:HALF_W]}) * w_fac[k]);
                r_prod[k] <= (FULL_W'(r_phi[k]) <<< HALF_W) + FULL_W'(r_plo[k]);
                r_mom[k]  <= n_mom[k];
            end
            r_zero <= {r_zero[0], i_zero};
            r_flag <= r_zero[1] | (|w_sat);
        end
    end

    assign o_vld   = r_vld[2];
    assign o_mom_x = r_mom[0];
    assign o_mom_y = r_mom[1];
    assign o_mom_z = r_mom[2];
    assign o_flag  = r_flag;

endmodule

// ===== rtl/helix_to_momentum_unit.sv =====
// Top level: track helix parameters in, momentum components out.
`timescale 1ns / 1ps
// Converts one helix beat (curvature, azimuth, dip slope) into px, py, pz in
// Q9.16 GeV with the field strength register setting eB. One beat is accepted
// every cycle while the output is not stalled; each result passes through
// two input stages, 39 chain cells (one quotient bit of pT = eB/|omega| per
// cell, with the first 18 cells also doing one sine/cosine rotation step each),
// and three stages of split multiplication and saturation. Zero curvature or
// any saturated component sets the range flag. A field write takes effect for
// beats accepted at the same clock edge or later. A stall on the output holds
// the whole pipeline.
module helix_to_momentum_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [htm_pkg::FIELD_W-1:0]   i_cfg_wdata,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // [23:0] curvature, [39:24] azimuth, [59:40] dip_slope, rest zero
    input  logic [htm_pkg::IN_W-1:0]      i_s_tdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [25:0] mom_x, [51:26] mom_y, [77:52] mom_z, rest zero
    output logic [htm_pkg::OUT_W-1:0]     o_m_tdata,
    // [0] range_flag
    output logic                          o_m_tuser
);

    localparam int AZ_LO = htm_pkg::CURV_W;
    localparam int SL_LO = htm_pkg::CURV_W + htm_pkg::AZ_W;

    logic                                   w_adv;
    logic [htm_pkg::FIELD_W-1:0]            r_field;
    logic                                   r_vld0;
    logic signed [htm_pkg::CURV_W-1:0]      r_curv;
    logic [htm_pkg::AZ_W-1:0]               r_az;
    logic signed [htm_pkg::SLOPE_W-1:0]     r_slope;
    logic                                   r_vld1;
    htm_pkg::t_cell                         r_head;
    htm_pkg::t_cell                         n_head;
    logic [htm_pkg::PROD_W-1:0]             w_prod;
    logic                                   w_vld [htm_pkg::DIV_STEPS+1];
    htm_pkg::t_cell                         w_cell [htm_pkg::DIV_STEPS+1];
    htm_pkg::t_cell                         w_tail;
    logic [htm_pkg::PT_W-1:0]               w_pt;
    logic signed [htm_pkg::XY_W-1:0]        w_cos;
    logic signed [htm_pkg::XY_W-1:0]        w_sin;
    logic                                   w_out_vld;
    logic signed [htm_pkg::MOM_W-1:0]       w_mom_x;
    logic signed [htm_pkg::MOM_W-1:0]       w_mom_y;
    logic signed [htm_pkg::MOM_W-1:0]       w_mom_z;
    logic                                   w_flag;

    // Advance everything unless a held result is stalled
    assign w_adv      = !w_out_vld || i_m_tready;
    assign o_s_tready = w_adv;

    // Field strength register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field <= htm_pkg::FIELD_W'(229376);
        end else if (i_cfg_we) begin
            r_field <= i_cfg_wdata;
        end
    end

    // Input stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
            r_vld1 <= 1'b0;
        end else if (w_adv) begin
            r_vld0 <= i_s_tvalid;
            r_vld1 <= r_vld0;
        end
    end

    // Capture the beat
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_curv  <= i_s_tdata[htm_pkg::CURV_W-1:0];
            r_az    <= i_s_tdata[AZ_LO +: htm_pkg::AZ_W];
            r_slope <= i_s_tdata[SL_LO +: htm_pkg::SLOPE_W];
        end
    end

    // Build the chain head: dividend, divisor, start vector, quadrant
    always_comb begin
        w_prod       = htm_pkg::PROD_W'(r_field) * htm_pkg::PROD_W'(htm_pkg::EB_SCALE);
        n_head.rem   = '0;
        n_head.num   = w_prod[htm_pkg::PROD_W-1:htm_pkg::PROD_W-htm_pkg::NUM_W];
        n_head.quo   = '0;
        n_head.div   = r_curv[htm_pkg::CURV_W-1] ? htm_pkg::DIV_W'(-r_curv)
                                                 : htm_pkg::DIV_W'(r_curv);
        n_head.x     = htm_pkg::CORDIC_START;
        n_head.y     = '0;
        n_head.z     = $signed({2'b00, r_az[htm_pkg::AZ_W-3:0], 16'b0});
        n_head.quad  = htm_pkg::t_quad'(r_az[htm_pkg::AZ_W-1:htm_pkg::AZ_W-2]);
        n_head.slope = r_slope;
        n_head.zero  = (r_curv == '0);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_head <= n_head;
        end
    end

    assign w_vld[0]  = r_vld1;
    assign w_cell[0] = r_head;

    // Chain of cells
    for (genvar g = 0; g < htm_pkg::DIV_STEPS; g++) begin : g_cell
        htm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_vld   (w_vld[g]),
            .i_stage ((g < htm_pkg::ATAN_LEN) ? htm_pkg::STAGE_W'(g) : '0),
            .i_rot   ((g < htm_pkg::CORDIC_STEPS) ? 1'b1 : 1'b0),
            .i_cell  (w_cell[g]),
            .o_vld   (w_vld[g+1]),
            .o_cell  (w_cell[g+1])
        );
    end

    // Map quadrant and form pT
    always_comb begin
        w_tail = w_cell[htm_pkg::DIV_STEPS];
        w_pt   = w_tail.zero ? {1'b1, {(htm_pkg::PT_W-1){1'b0}}} : {1'b0, w_tail.quo};
        case (w_tail.quad)
            htm_pkg::Q_FIRST: begin
                w_cos = w_tail.x;
                w_sin = w_tail.y;
            end
            htm_pkg::Q_SECOND: begin
                w_cos = -w_tail.y;
                w_sin = w_tail.x;
            end
            htm_pkg::Q_THIRD: begin
                w_cos = -w_tail.x;
                w_sin = -w_tail.y;
            end
            default: begin
                w_cos = w_tail.y;
                w_sin = -w_tail.x;
            end
        endcase
    end

    htm_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vld   (w_vld[htm_pkg::DIV_STEPS]),
        .i_pt    (w_pt),
        .i_cos   (w_cos),
        .i_sin   (w_sin),
        .i_slope (w_tail.slope),
        .i_zero  (w_tail.zero),
        .o_vld   (w_out_vld),
        .o_mom_x (w_mom_x),
        .o_mom_y (w_mom_y),
        .o_mom_z (w_mom_z),
        .o_flag  (w_flag)
    );

    // Drive the output beat
    assign o_m_tvalid = w_out_vld;
    assign o_m_tdata  = {{(htm_pkg::OUT_W-htm_pkg::OUT_BITS){1'b0}}, w_mom_z, w_mom_y, w_mom_x};
    assign o_m_tuser  = w_flag;

endmodule

// ===== tb/sv/tb_helix_to_momentum_unit.sv =====
// Testbench for the helix-to-momentum unit: directed and random beats checked against a predictor.
`timescale 1ns / 1ps
module tb_helix_to_momentum_unit;
    import htm_pkg::*;

    localparam longint EB_CONST = 64'd329625293;
    localparam longint PT_ZERO = 64'sd1 << 39;
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic               flag;
        logic [MOM_W-1:0]   mz;
        logic [MOM_W-1:0]   my;
        logic [MOM_W-1:0]   mx;
    } t_momentum;

    // Predicts momentum for each accepted helix beat and checks the results in order
    class momentum_board;
        logic [FIELD_W-1:0] field;
        t_momentum pending[$];
        int errors;
        int reported;

        function new();
            field = 20'd229376;
            errors = 0;
            reported = 0;
        endfunction

        function longint shr_floor(longint v, int s);
            return v >>> s;
        endfunction

        function longint clamp26(longint v, ref logic flag);
            if (v > 64'sd33554431) begin
                flag = 1'b1;
                return 64'sd33554431;
            end
            if (v < -64'sd33554432) begin
                flag = 1'b1;
                return -64'sd33554432;
            end
            return v;
        endfunction

        function void note_helix(logic signed [CURV_W-1:0] curv, logic [AZ_W-1:0] az,
                                 logic signed [SLOPE_W-1:0] slope);
            longint pt, x, y, z, dx, dy, c, s, mag;
            logic flag;
            t_momentum m;
            t_quad q;
            flag = 1'b0;
            if (curv == 0) begin
                pt = PT_ZERO;
                flag = 1'b1;
            end else begin
                mag = (curv < 0) ? -longint'(curv) : longint'(curv);
                pt = (longint'(field) * EB_CONST) / (mag << 10);
            end
            // rotate the start vector through the angle within the quadrant
            x = 5094007;
            y = 0;
            z = longint'(az[13:0]) << 16;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= longint'(atan_at(STAGE_W'(i)));
                end else begin
                    x += dx; y -= dy; z += longint'(atan_at(STAGE_W'(i)));
                end
            end
            q = t_quad'(az[15:14]);
            case (q)
                Q_FIRST:  begin c = x;  s = y;  end
                Q_SECOND: begin c = -y; s = x;  end
                Q_THIRD:  begin c = -x; s = -y; end
                default:  begin c = y;  s = -x; end
            endcase
            m.mx = MOM_W'(clamp26(shr_floor(pt * c, CS_SHIFT), flag));
            m.my = MOM_W'(clamp26(shr_floor(pt * s, CS_SHIFT), flag));
            m.mz = MOM_W'(clamp26(shr_floor(pt * longint'(slope), TAN_SHIFT), flag));
            m.flag = flag;
            pending = {pending, m};
        endfunction

        function void check_momentum(t_momentum got);
            t_momentum want;
            if (pending.size() == 0) begin
                errors++;
                if (reported < 10) begin
                    reported++;
                    $display("unexpected result %h", got);
                end
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                errors++;
                if (reported < 10) begin
                    reported++;
                    $display("result: exp x=%h y=%h z=%h f=%b got x=%h y=%h z=%h f=%b",
                             want.mx, want.my, want.mz, want.flag,
                             got.mx, got.my, got.mz, got.flag);
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [FIELD_W-1:0] i_cfg_wdata = '0;
    logic i_s_tvalid = 1'b0;
    logic o_s_tready;
    logic [IN_W-1:0] i_s_tdata = '0;
    logic o_m_tvalid;
    logic i_m_tready = 1'b0;
    logic [OUT_W-1:0] o_m_tdata;
    logic o_m_tuser;

    momentum_board board = new();
    int send_idle = 0;
    int recv_stall = 0;
    int quiet_cycles = 0;

    always #4 i_clk = ~i_clk;

    helix_to_momentum_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser)
    );

    // Sample accepted result beats and drive the receiver stall pattern
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            board.check_momentum({o_m_tuser, o_m_tdata[OUT_BITS-1:0]});
        i_m_tready <= ($urandom_range(99) >= recv_stall);
    end

    // Watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("helix_to_momentum_unit: mismatch");
            $finish;
        end
    end

    // Present one helix beat, wait for acceptance, note it
    task automatic send_helix(logic signed [CURV_W-1:0] curv, logic [AZ_W-1:0] az,
                              logic signed [SLOPE_W-1:0] slope);
        while ($urandom_range(99) < send_idle) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {{(IN_W - IN_BITS){1'b0}}, slope, az, curv};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        board.note_helix(curv, az, slope);
    endtask

    // Drop valid and wait until every expected result has arrived, then idle before returning
    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_field(logic [FIELD_W-1:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.field = v;
    endtask

    // Random helix: mostly small or moderate curvatures, sometimes extremes
    task automatic send_random();
        logic signed [CURV_W-1:0] curv;
        logic signed [SLOPE_W-1:0] slope;
        case ($urandom_range(9))
            0: curv = '0;
            1: curv = CURV_W'($urandom_range(15) - 8);
            2, 3: curv = CURV_W'($urandom);
            default: curv = CURV_W'($signed(24'($urandom_range(65535))) - 32768);
        endcase
        slope = SLOPE_W'($urandom);
        send_helix(curv, 16'($urandom), slope);
    endtask

    initial begin
        logic [FIELD_W-1:0] fields[4];
        int idle_set[4][2];
        fields = '{20'd0, 20'hFFFFF, 20'd65536, 20'd229376};
        idle_set = '{'{0, 0}, '{62, 0}, '{0, 62}, '{23, 23}};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, every quadrant, zero curvature, both slope signs
        send_helix(24'sd0, 16'h0000, 20'sd65536);
        send_helix(24'sd0, 16'h4000, -20'sd1);
        send_helix(24'sd0, 16'h2000, 20'sd0);
        send_helix(24'sh7FFFFF, 16'h0000, 20'sh7FFFF);
        send_helix(24'sh800000, 16'hFFFF, 20'sh80000);
        send_helix(24'sd1, 16'h4000, 20'sd65536);
        send_helix(-24'sd1, 16'h8000, -20'sd65536);
        send_helix(24'sd1000, 16'hC000, 20'sd12345);
        send_helix(-24'sd4096, 16'h1234, -20'sd777);
        send_helix(24'sd300000, 16'h5555, 20'sd0);
        send_helix(24'sd65536, 16'hAAAA, 20'sh7FFFF);
        send_helix(-24'sd65536, 16'h3FFF, 20'sh80000);
        send_helix(24'sd2, 16'hBFFF, 20'sd1);
        drain();

        // Phases over field settings and idling patterns
        for (int p = 0; p < 4; p++) begin
            write_field(fields[p]);
            if (p == 0) begin
                send_helix(24'sd0, 16'h1000, 20'sd5);
                send_helix(24'sd77, 16'h7000, -20'sd5);
            end
            for (int k = 0; k < 4; k++) begin
                send_idle = idle_set[k][0];
                recv_stall = idle_set[k][1];
                for (int n = 0; n < 52; n++) send_random();
                if (k == 1) drain();
            end
            send_idle = 0;
            recv_stall = 0;
            drain();
        end
        write_field(20'd12345);
        for (int n = 0; n < 30; n++) send_random();
        drain();

        if (board.errors == 0)
            $display("helix_to_momentum_unit: match");
        else
            $display("helix_to_momentum_unit: mismatch");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/htm_pkg.sv
rtl/htm_cell.sv
rtl/htm_mul.sv
rtl/helix_to_momentum_unit.sv
tb/sv/tb_helix_to_momentum_unit.sv
